/* design/slab_slot_allocator_top_macros.svh */
// Assertion macros for the slab slot allocator.
// Each check samples on the rising edge of clk and is held off while rst_n is low.
`ifndef SLAB_SLOT_ALLOCATOR_TOP_MACROS_SVH
`define SLAB_SLOT_ALLOCATOR_TOP_MACROS_SVH
`ifndef SYNTHESIS
`define SSA_CHECK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define SSA_CHECK_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) ante |=> cons) else $error(msg);
`else
`define SSA_CHECK(label, prop, msg)
`define SSA_CHECK_NEXT(label, ante, cons, msg)
`endif
`endif

/* design/ssa_pkg.sv */
package ssa_pkg;

  localparam int SLAB_SLOTS = 16;
  localparam int MAX_SLABS  = 64;

  localparam int SLOT_W  = $clog2(SLAB_SLOTS);
  localparam int FRAME_W = $clog2(MAX_SLABS);
  localparam int CNT_W   = $clog2(MAX_SLABS + 1);
  localparam int FC_W    = $clog2(SLAB_SLOTS + 1);
  localparam int STK_AW  = FRAME_W + SLOT_W;

  // Grouping of the free-frame search
  localparam int GRP_W  = 8;
  localparam int GRP_OW = $clog2(GRP_W);
  localparam int N_GRP  = MAX_SLABS / GRP_W;

  // Stream widths
  localparam int ACT_W       = 2;
  localparam int STAT_W      = 2;
  localparam int IN_TDATA_W  = 16;
  localparam int OUT_TDATA_W = 24;

  // Actions
  localparam logic [ACT_W-1:0] ACT_ALLOC  = 2'd0;
  localparam logic [ACT_W-1:0] ACT_RETURN = 2'd1;
  localparam logic [ACT_W-1:0] ACT_TRIM   = 2'd2;

  // Status codes
  localparam logic [STAT_W-1:0] ST_OK       = 2'd0;
  localparam logic [STAT_W-1:0] ST_NO_FRAME = 2'd1;
  localparam logic [STAT_W-1:0] ST_NOT_USED = 2'd2;
  localparam logic [STAT_W-1:0] ST_FULL     = 2'd3;

  typedef struct packed {
    logic               found;
    logic [FRAME_W-1:0] frame;
  } pick_t;

endpackage

/* design/ssa_frame_pick.sv */
module ssa_frame_pick (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic [ssa_pkg::MAX_SLABS-1:0]  used,
  output ssa_pkg::pick_t                 pick
);
  import ssa_pkg::*;

  logic [N_GRP-1:0]  grp_any_r;
  logic [GRP_OW-1:0] grp_off_r [N_GRP];
  logic [N_GRP-1:0]  grp_any_nxt;
  logic [GRP_OW-1:0] grp_off_nxt [N_GRP];
  pick_t             pick_r;
  pick_t             pick_nxt;

  // Find the lowest free frame in each group
  always_comb begin
    for (int g = 0; g < N_GRP; g++) begin
      grp_any_nxt[g] = 1'b0;
      grp_off_nxt[g] = '0;
      for (int b = GRP_W - 1; b >= 0; b--) begin
        if (!used[g*GRP_W + b]) begin
          grp_any_nxt[g] = 1'b1;
          grp_off_nxt[g] = GRP_OW'(b);
        end
      end
    end
  end

  // Pick the lowest group that has a free frame
  always_comb begin
    pick_nxt = '0;
    for (int g = N_GRP - 1; g >= 0; g--) begin
      if (grp_any_r[g]) begin
        pick_nxt.found = 1'b1;
        pick_nxt.frame = (FRAME_W'(g) << GRP_OW) | FRAME_W'(grp_off_r[g]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grp_any_r <= '0;
      pick_r    <= '0;
    end else begin
      grp_any_r <= grp_any_nxt;
      pick_r    <= pick_nxt;
    end
  end

  always_ff @(posedge clk) begin
    for (int g = 0; g < N_GRP; g++) begin
      grp_off_r[g] <= grp_off_nxt[g];
    end
  end

  assign pick = pick_r;

endmodule

/* design/slab_slot_allocator_top.sv */
// Slab slot allocator. One item is taken at a time and one result is given for each.
// Allocate from the hinted slab reads the slab table, then the free count, then the free
// stack, and scans forward for the next slab with a free slot when that slab runs dry.
// Allocate that builds a new slab waits for the frame picker, then writes the 16-entry
// free stack of the new frame one entry per cycle. Return reads the free count and the
// logical map, then pushes the slot. Trim checks each table entry, then rescans the hint.
// The per-frame counters, slab table, logical map and free stacks are synchronous memories
// with one write and one registered read port each, read one entry per cycle. The memories
// need no clearing after reset; the frame in-use bits do, and reset clears them at once.
`include "slab_slot_allocator_top_macros.svh"

module slab_slot_allocator_top (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [ssa_pkg::ACT_W-1:0]         in_tuser,   // action
  input  logic [ssa_pkg::IN_TDATA_W-1:0]    in_tdata,   // frame_index, slot_index
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [ssa_pkg::STAT_W-1:0]        out_tuser,  // status
  output logic [ssa_pkg::OUT_TDATA_W-1:0]   out_tdata   // granted_frame, granted_slot,
                                                        // slabs_in_use
);
  import ssa_pkg::*;

  localparam logic [4:0] S_IDLE    = 5'd0;
  localparam logic [4:0] S_AL_F    = 5'd1;
  localparam logic [4:0] S_AL_C    = 5'd2;
  localparam logic [4:0] S_AL_S    = 5'd3;
  localparam logic [4:0] S_NS_W1   = 5'd4;
  localparam logic [4:0] S_NS_W2   = 5'd5;
  localparam logic [4:0] S_NS_CHK  = 5'd6;
  localparam logic [4:0] S_NS_FILL = 5'd7;
  localparam logic [4:0] S_HS_CHK  = 5'd8;
  localparam logic [4:0] S_HS_F    = 5'd9;
  localparam logic [4:0] S_HS_C    = 5'd10;
  localparam logic [4:0] S_R_C     = 5'd11;
  localparam logic [4:0] S_T_CHK   = 5'd12;
  localparam logic [4:0] S_T_F     = 5'd13;
  localparam logic [4:0] S_T_C     = 5'd14;
  localparam logic [4:0] S_T_M     = 5'd15;
  localparam logic [4:0] S_FIN     = 5'd16;

  localparam int OUT_USED = FRAME_W + SLOT_W + CNT_W;

  // Control state
  logic [4:0]          state_r, state_nxt;
  logic [CNT_W-1:0]    cnt_r, cnt_nxt;
  logic [CNT_W-1:0]    ff_r, ff_nxt;
  logic [CNT_W-1:0]    idx_r, idx_nxt;
  logic [MAX_SLABS-1:0] fu_r, fu_nxt;
  logic                out_valid_r, out_valid_nxt;

  // Item and work registers
  logic [FRAME_W-1:0]  frm_r, frm_nxt;
  logic [SLOT_W-1:0]   slot_r, slot_nxt;
  logic [FRAME_W-1:0]  cur_f_r, cur_f_nxt;
  logic [FC_W-1:0]     cc_r, cc_nxt;
  logic [SLOT_W-1:0]   fill_r, fill_nxt;
  logic [STAT_W-1:0]   res_status_r, res_status_nxt;
  logic [FRAME_W-1:0]  res_frame_r, res_frame_nxt;
  logic [SLOT_W-1:0]   res_slot_r, res_slot_nxt;
  logic [STAT_W-1:0]   out_status_r, out_status_nxt;
  logic [FRAME_W-1:0]  out_frame_r, out_frame_nxt;
  logic [SLOT_W-1:0]   out_slot_r, out_slot_nxt;
  logic [CNT_W-1:0]    out_cnt_r, out_cnt_nxt;

  // Memories
  logic [FC_W-1:0]     fc_mem [MAX_SLABS];
  logic [FRAME_W-1:0]  st_mem [MAX_SLABS];
  logic [FRAME_W-1:0]  fl_mem [MAX_SLABS];
  logic [SLOT_W-1:0]   fs_mem [MAX_SLABS*SLAB_SLOTS];

  logic                fc_we, st_we, fl_we, fs_we;
  logic [FRAME_W-1:0]  fc_wa, fc_ra, st_wa, st_ra, fl_wa, fl_ra;
  logic [STK_AW-1:0]   fs_wa, fs_ra;
  logic [FC_W-1:0]     fc_wd, fc_rd_r;
  logic [FRAME_W-1:0]  st_wd, st_rd_r, fl_wd, fl_rd_r;
  logic [SLOT_W-1:0]   fs_wd, fs_rd_r;

  pick_t               pick;
  logic                in_xfer;
  logic [FC_W-1:0]     fc_dec;
  logic [CNT_W-1:0]    cnt_dec;

  ssa_frame_pick u_pick (
    .clk   (clk),
    .rst_n (rst_n),
    .used  (fu_r),
    .pick  (pick)
  );

  assign in_tready = (state_r == S_IDLE);
  assign in_xfer   = in_tvalid && in_tready;
  assign fc_dec    = fc_rd_r - FC_W'(1);
  assign cnt_dec   = cnt_r - CNT_W'(1);

  // Sequencer: one memory access per port per cycle, the next read waits for the write
  always_comb begin
    state_nxt      = state_r;
    cnt_nxt        = cnt_r;
    ff_nxt         = ff_r;
    idx_nxt        = idx_r;
    fu_nxt         = fu_r;
    frm_nxt        = frm_r;
    slot_nxt       = slot_r;
    cur_f_nxt      = cur_f_r;
    cc_nxt         = cc_r;
    fill_nxt       = fill_r;
    res_status_nxt = res_status_r;
    res_frame_nxt  = res_frame_r;
    res_slot_nxt   = res_slot_r;
    out_valid_nxt  = out_valid_r && !out_tready;
    out_status_nxt = out_status_r;
    out_frame_nxt  = out_frame_r;
    out_slot_nxt   = out_slot_r;
    out_cnt_nxt    = out_cnt_r;
    fc_we = 1'b0; fc_wa = '0; fc_wd = '0; fc_ra = '0;
    st_we = 1'b0; st_wa = '0; st_wd = '0; st_ra = '0;
    fl_we = 1'b0; fl_wa = '0; fl_wd = '0; fl_ra = '0;
    fs_we = 1'b0; fs_wa = '0; fs_wd = '0; fs_ra = '0;

    case (state_r)
      S_IDLE: begin
        if (in_xfer) begin
          frm_nxt        = in_tdata[FRAME_W-1:0];
          slot_nxt       = in_tdata[FRAME_W +: SLOT_W];
          res_status_nxt = ST_OK;
          res_frame_nxt  = '0;
          res_slot_nxt   = '0;
          case (in_tuser)
            ACT_ALLOC: begin
              if (ff_r < cnt_r) begin
                st_ra     = ff_r[FRAME_W-1:0];
                state_nxt = S_AL_F;
              end else begin
                state_nxt = S_NS_W1;
              end
            end
            ACT_RETURN: begin
              if (!fu_r[in_tdata[FRAME_W-1:0]]) begin
                res_status_nxt = ST_NOT_USED;
                state_nxt      = S_FIN;
              end else begin
                fc_ra     = in_tdata[FRAME_W-1:0];
                fl_ra     = in_tdata[FRAME_W-1:0];
                state_nxt = S_R_C;
              end
            end
            ACT_TRIM: begin
              idx_nxt   = '0;
              state_nxt = S_T_CHK;
            end
            default: state_nxt = S_FIN;
          endcase
        end
      end

      // Allocate from the hinted slab
      S_AL_F: begin
        cur_f_nxt = st_rd_r;
        fc_ra     = st_rd_r;
        state_nxt = S_AL_C;
      end
      S_AL_C: begin
        if (fc_rd_r == '0) begin
          ff_nxt    = CNT_W'(MAX_SLABS);
          state_nxt = S_NS_W1;
        end else begin
          fc_we     = 1'b1;
          fc_wa     = cur_f_r;
          fc_wd     = fc_dec;
          fs_ra     = {cur_f_r, fc_dec[SLOT_W-1:0]};
          cc_nxt    = fc_dec;
          state_nxt = S_AL_S;
        end
      end
      S_AL_S: begin
        res_frame_nxt = cur_f_r;
        res_slot_nxt  = fs_rd_r;
        if (cc_r == '0) begin
          idx_nxt   = ff_r + CNT_W'(1);
          state_nxt = S_HS_CHK;
        end else begin
          state_nxt = S_FIN;
        end
      end

      // Build a new slab in the lowest free frame; let the picker settle first
      S_NS_W1: state_nxt = S_NS_W2;
      S_NS_W2: state_nxt = S_NS_CHK;
      S_NS_CHK: begin
        if (cnt_r >= CNT_W'(MAX_SLABS) || !pick.found) begin
          res_status_nxt = ST_NO_FRAME;
          state_nxt      = S_FIN;
        end else begin
          cur_f_nxt          = pick.frame;
          fu_nxt[pick.frame] = 1'b1;
          fill_nxt           = '0;
          state_nxt          = S_NS_FILL;
        end
      end
      S_NS_FILL: begin
        fs_we    = 1'b1;
        fs_wa    = {cur_f_r, fill_r};
        fs_wd    = SLOT_W'(SLAB_SLOTS - 1) - fill_r;
        fill_nxt = fill_r + SLOT_W'(1);
        if (fill_r == SLOT_W'(SLAB_SLOTS - 1)) begin
          // Commit the slab and pop its top slot, which is slot zero
          fc_we         = 1'b1;
          fc_wa         = cur_f_r;
          fc_wd         = FC_W'(SLAB_SLOTS - 1);
          st_we         = 1'b1;
          st_wa         = cnt_r[FRAME_W-1:0];
          st_wd         = cur_f_r;
          fl_we         = 1'b1;
          fl_wa         = cur_f_r;
          fl_wd         = cnt_r[FRAME_W-1:0];
          ff_nxt        = cnt_r;
          cnt_nxt       = cnt_r + CNT_W'(1);
          res_frame_nxt = cur_f_r;
          res_slot_nxt  = '0;
          state_nxt     = S_FIN;
        end
      end

      // Scan forward for the next slab with a free slot
      S_HS_CHK: begin
        if (idx_r >= cnt_r) begin
          ff_nxt    = CNT_W'(MAX_SLABS);
          state_nxt = S_FIN;
        end else begin
          st_ra     = idx_r[FRAME_W-1:0];
          state_nxt = S_HS_F;
        end
      end
      S_HS_F: begin
        fc_ra     = st_rd_r;
        state_nxt = S_HS_C;
      end
      S_HS_C: begin
        if (fc_rd_r != '0) begin
          ff_nxt    = idx_r;
          state_nxt = S_FIN;
        end else begin
          idx_nxt   = idx_r + CNT_W'(1);
          state_nxt = S_HS_CHK;
        end
      end

      // Push a returned slot
      S_R_C: begin
        if (fc_rd_r >= FC_W'(SLAB_SLOTS)) begin
          res_status_nxt = ST_FULL;
        end else begin
          fs_we = 1'b1;
          fs_wa = {frm_r, fc_rd_r[SLOT_W-1:0]};
          fs_wd = slot_r;
          fc_we = 1'b1;
          fc_wa = frm_r;
          fc_wd = fc_rd_r + FC_W'(1);
          if ({1'b0, fl_rd_r} < ff_r) begin
            ff_nxt = {1'b0, fl_rd_r};
          end
        end
        state_nxt = S_FIN;
      end

      // Trim: drop fully free slabs, moving the last entry into the gap
      S_T_CHK: begin
        if (idx_r >= cnt_r) begin
          idx_nxt   = '0;
          state_nxt = S_HS_CHK;
        end else begin
          st_ra     = idx_r[FRAME_W-1:0];
          state_nxt = S_T_F;
        end
      end
      S_T_F: begin
        cur_f_nxt = st_rd_r;
        fc_ra     = st_rd_r;
        state_nxt = S_T_C;
      end
      S_T_C: begin
        if (fc_rd_r != FC_W'(SLAB_SLOTS)) begin
          idx_nxt   = idx_r + CNT_W'(1);
          state_nxt = S_T_CHK;
        end else begin
          fu_nxt[cur_f_r] = 1'b0;
          st_ra           = cnt_dec[FRAME_W-1:0];
          state_nxt       = S_T_M;
        end
      end
      S_T_M: begin
        st_we   = 1'b1;
        st_wa   = idx_r[FRAME_W-1:0];
        st_wd   = st_rd_r;
        cnt_nxt = cnt_dec;
        if (idx_r < cnt_dec) begin
          fl_we = 1'b1;
          fl_wa = st_rd_r;
          fl_wd = idx_r[FRAME_W-1:0];
        end
        state_nxt = S_T_CHK;
      end

      // Hand the result to the output register once it is free
      S_FIN: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = res_status_r;
          out_frame_nxt  = res_frame_r;
          out_slot_nxt   = res_slot_r;
          out_cnt_nxt    = cnt_r;
          state_nxt      = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      ff_r        <= CNT_W'(MAX_SLABS);
      idx_r       <= '0;
      fu_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      ff_r        <= ff_nxt;
      idx_r       <= idx_nxt;
      fu_r        <= fu_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    frm_r        <= frm_nxt;
    slot_r       <= slot_nxt;
    cur_f_r      <= cur_f_nxt;
    cc_r         <= cc_nxt;
    fill_r       <= fill_nxt;
    res_status_r <= res_status_nxt;
    res_frame_r  <= res_frame_nxt;
    res_slot_r   <= res_slot_nxt;
    out_status_r <= out_status_nxt;
    out_frame_r  <= out_frame_nxt;
    out_slot_r   <= out_slot_nxt;
    out_cnt_r    <= out_cnt_nxt;
  end

  // Memory ports: one write and one registered read each
  always_ff @(posedge clk) begin
    if (fc_we) fc_mem[fc_wa] <= fc_wd;
    fc_rd_r <= fc_mem[fc_ra];
  end

  always_ff @(posedge clk) begin
    if (st_we) st_mem[st_wa] <= st_wd;
    st_rd_r <= st_mem[st_ra];
  end

  always_ff @(posedge clk) begin
    if (fl_we) fl_mem[fl_wa] <= fl_wd;
    fl_rd_r <= fl_mem[fl_ra];
  end

  always_ff @(posedge clk) begin
    if (fs_we) fs_mem[fs_wa] <= fs_wd;
    fs_rd_r <= fs_mem[fs_ra];
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_status_r;
  assign out_tdata  = {{(OUT_TDATA_W - OUT_USED){1'b0}}, out_cnt_r, out_slot_r, out_frame_r};

  `SSA_CHECK(a_cnt_range, (cnt_r <= CNT_W'(MAX_SLABS)), "slab count beyond pool")
  `SSA_CHECK(a_hint_ok, (state_r != S_IDLE || ff_r < cnt_r || ff_r == CNT_W'(MAX_SLABS)), "bad hint")
  `SSA_CHECK(a_used_match, (state_r != S_IDLE || $countones(fu_r) == int'(cnt_r)), "in-use mismatch")
  `SSA_CHECK_NEXT(a_accept_busy, in_xfer, (state_r != S_IDLE), "accepted item left sequencer idle")

endmodule

/* tb/testbench.sv */
`timescale 1ns / 1ps

module testbench;
  import ssa_pkg::*;

  localparam logic [ACT_W-1:0] ACT_NOP = 2'd3;
  localparam int DRAIN_CYCLES = 600;

  typedef struct packed {
    logic [STAT_W-1:0]  status;
    logic [FRAME_W-1:0] frame;
    logic [SLOT_W-1:0]  slot;
    logic [CNT_W-1:0]   slabs;
  } grant_t;

  logic                   clk;
  logic                   rst_n;
  logic                   in_tvalid;
  logic                   in_tready;
  logic [ACT_W-1:0]       in_tuser;
  logic [IN_TDATA_W-1:0]  in_tdata;
  logic                   out_tvalid;
  logic                   out_tready;
  logic [STAT_W-1:0]      out_tuser;
  logic [OUT_TDATA_W-1:0] out_tdata;

  slab_slot_allocator_top dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tuser   (in_tuser),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tuser  (out_tuser),
    .out_tdata  (out_tdata)
  );

  // Shadow copy of the allocator state
  logic [FC_W-1:0]    free_cnt  [MAX_SLABS];
  logic [SLOT_W-1:0]  slot_stk  [MAX_SLABS*SLAB_SLOTS];
  logic [FRAME_W-1:0] slab_map  [MAX_SLABS];
  logic [FRAME_W-1:0] logic_idx [MAX_SLABS];
  bit                 in_use    [MAX_SLABS];
  logic [CNT_W-1:0]   n_slabs;
  logic [CNT_W-1:0]   hint;

  grant_t                       pending_grants[$];
  logic [FRAME_W+SLOT_W-1:0]    held_slots[$];
  int                           errors;
  int                           hold_cycles;
  bit                           no_gaps;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #20ms;
    $display("Simulation FAILED");
    $finish;
  end

  // Search for the first slab with free slots from a logical index on
  function automatic void rescan_hint(input int from);
    hint = CNT_W'(MAX_SLABS);
    for (int i = from; i < n_slabs; i++) begin
      if (free_cnt[slab_map[i]] != 0) begin
        hint = CNT_W'(i);
        return;
      end
    end
  endfunction

  function automatic grant_t predict_grant(input logic [ACT_W-1:0] act,
                                           input logic [FRAME_W-1:0] fr,
                                           input logic [SLOT_W-1:0] sl);
    grant_t g;
    int f;
    int c;
    int i;
    bit ok;
    g = '0;
    g.status = ST_OK;
    case (act)
      ACT_ALLOC: begin
        if (hint < n_slabs && free_cnt[slab_map[hint]] == 0) hint = CNT_W'(MAX_SLABS);
        ok = 1'b1;
        if (hint >= n_slabs) begin
          // Build a new slab in the lowest free frame
          f = MAX_SLABS;
          if (n_slabs < MAX_SLABS) begin
            for (i = MAX_SLABS - 1; i >= 0; i--) if (!in_use[i]) f = i;
          end
          if (f >= MAX_SLABS) begin
            ok = 1'b0;
          end else begin
            in_use[f] = 1'b1;
            free_cnt[f] = FC_W'(SLAB_SLOTS);
            for (i = 0; i < SLAB_SLOTS; i++)
              slot_stk[f*SLAB_SLOTS+i] = SLOT_W'(SLAB_SLOTS - 1 - i);
            slab_map[n_slabs] = FRAME_W'(f);
            logic_idx[f] = FRAME_W'(n_slabs);
            hint = n_slabs;
            n_slabs = n_slabs + CNT_W'(1);
          end
        end
        if (!ok) begin
          g.status = ST_NO_FRAME;
        end else begin
          f = slab_map[hint];
          c = free_cnt[f] - 1;
          free_cnt[f] = FC_W'(c);
          g.frame = FRAME_W'(f);
          g.slot = slot_stk[f*SLAB_SLOTS + c];
          if (c == 0) rescan_hint(hint + 1);
        end
      end
      ACT_RETURN: begin
        if (!in_use[fr]) begin
          g.status = ST_NOT_USED;
        end else if (free_cnt[fr] >= SLAB_SLOTS) begin
          g.status = ST_FULL;
        end else begin
          slot_stk[fr*SLAB_SLOTS + free_cnt[fr]] = sl;
          free_cnt[fr] = free_cnt[fr] + FC_W'(1);
          if (logic_idx[fr] < hint) hint = CNT_W'(logic_idx[fr]);
        end
      end
      ACT_TRIM: begin
        // Release fully free slabs, filling each gap from the table end
        i = 0;
        while (i < n_slabs) begin
          f = slab_map[i];
          if (free_cnt[f] != SLAB_SLOTS) begin
            i++;
          end else begin
            in_use[f] = 1'b0;
            slab_map[i] = slab_map[n_slabs-1];
            n_slabs = n_slabs - CNT_W'(1);
            if (i < n_slabs) logic_idx[slab_map[i]] = FRAME_W'(i);
          end
        end
        rescan_hint(0);
      end
      default: ;
    endcase
    g.slabs = n_slabs;
    return g;
  endfunction

  // Offer one item after a random gap; predict on transfer
  task automatic send_item(input logic [ACT_W-1:0] act, input logic [FRAME_W-1:0] fr,
                           input logic [SLOT_W-1:0] sl);
    int gap;
    grant_t g;
    gap = 0;
    if (!no_gaps) begin
      case ($urandom_range(0, 19))
        0, 1, 2, 3: gap = $urandom_range(1, 3);
        4:          gap = $urandom_range(10, 40);
        default:    gap = 0;
      endcase
    end
    if (gap > 0) begin
      @(negedge clk);
      in_tvalid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tuser  <= act;
    in_tdata  <= {{(IN_TDATA_W-FRAME_W-SLOT_W){1'b0}}, sl, fr};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    g = predict_grant(act, fr, sl);
    if (act == ACT_ALLOC && g.status == ST_OK) held_slots.push_back({g.slot, g.frame});
    pending_grants.push_back(g);
  endtask

  task automatic give_back_held(input int idx);
    logic [FRAME_W+SLOT_W-1:0] h;
    h = held_slots[idx];
    held_slots.delete(idx);
    send_item(ACT_RETURN, h[FRAME_W-1:0], h[FRAME_W+SLOT_W-1:FRAME_W]);
  endtask

  // Receiver: random stalls, plus a long hold-off on request
  initial begin
    int idle_left;
    idle_left = 0;
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_cycles > 0) begin
        out_tready <= 1'b0;
        hold_cycles--;
      end else if (idle_left > 0) begin
        out_tready <= 1'b0;
        idle_left--;
      end else begin
        out_tready <= 1'b1;
        if (!no_gaps) begin
          case ($urandom_range(0, 19))
            0, 1, 2: idle_left = $urandom_range(1, 3);
            3:       idle_left = $urandom_range(15, 50);
            default: idle_left = 0;
          endcase
        end
      end
    end
  end

  // Compare each result transfer with the oldest prediction
  always @(posedge clk) begin
    grant_t want;
    grant_t got;
    if (rst_n && out_tvalid && out_tready) begin
      got = {out_tuser, out_tdata[FRAME_W-1:0], out_tdata[FRAME_W+SLOT_W-1:FRAME_W],
             out_tdata[FRAME_W+SLOT_W+CNT_W-1:FRAME_W+SLOT_W]};
      if (pending_grants.size() == 0) begin
        $display("%0t: unexpected result status=%0d frame=%0d slot=%0d slabs=%0d",
                 $realtime, got.status, got.frame, got.slot, got.slabs);
        errors++;
      end else begin
        want = pending_grants.pop_front();
        if (got.status !== want.status) begin
          $display("%0t: status expected %0d actual %0d", $realtime, want.status, got.status);
          errors++;
        end
        if (got.frame !== want.frame) begin
          $display("%0t: frame expected %0d actual %0d", $realtime, want.frame, got.frame);
          errors++;
        end
        if (got.slot !== want.slot) begin
          $display("%0t: slot expected %0d actual %0d", $realtime, want.slot, got.slot);
          errors++;
        end
        if (got.slabs !== want.slabs) begin
          $display("%0t: slabs expected %0d actual %0d", $realtime, want.slabs, got.slabs);
          errors++;
        end
      end
    end
  end

  task automatic test_basic_ops();
    send_item(ACT_ALLOC, '0, '0);
    send_item(ACT_RETURN, 6'd63, 4'd15);
    give_back_held(0);
    // Fresh slab: every slot is free, so a return finds the stack full
    send_item(ACT_RETURN, 6'd0, 4'd0);
    send_item(ACT_NOP, 6'd63, 4'd15);
    send_item(ACT_TRIM, '0, '0);
    send_item(ACT_RETURN, 6'd0, 4'd3);
    repeat (3) send_item(ACT_ALLOC, '0, '0);
    give_back_held(1);
    send_item(ACT_ALLOC, '0, '0);
    send_item(ACT_TRIM, '0, '0);
  endtask

  // Fill every frame, ask once more, then hand part of the slots back and trim
  task automatic test_exhaust_pool();
    while (n_slabs < MAX_SLABS || hint < n_slabs) send_item(ACT_ALLOC, '0, '0);
    send_item(ACT_ALLOC, '0, '0);
    send_item(ACT_RETURN, 6'd5, 4'd9);
    send_item(ACT_ALLOC, '0, '0);
    repeat (160) give_back_held($urandom_range(0, held_slots.size() - 1));
    send_item(ACT_TRIM, '0, '0);
  endtask

  task automatic test_backpressure();
    no_gaps = 1'b1;
    @(negedge clk);
    hold_cycles = 300;
    repeat (30) send_item(ACT_ALLOC, '0, '0);
    no_gaps = 1'b0;
  endtask

  task automatic test_random_mix(input int n_items);
    int r;
    for (int k = 0; k < n_items; k++) begin
      r = $urandom_range(0, 99);
      if (r < 45 - held_slots.size() / 20)
        send_item(ACT_ALLOC, '0, '0);
      else if (r < 88 && held_slots.size() > 0)
        give_back_held($urandom_range(0, held_slots.size() - 1));
      else if (r < 93)
        send_item(ACT_TRIM, FRAME_W'($urandom), SLOT_W'($urandom));
      else
        send_item(ACT_W'($urandom), FRAME_W'($urandom), SLOT_W'($urandom));
    end
  endtask

  initial begin
    errors = 0;
    hold_cycles = 0;
    no_gaps = 1'b0;
    in_tvalid = 1'b0;
    in_tuser = '0;
    in_tdata = '0;
    n_slabs = '0;
    hint = CNT_W'(MAX_SLABS);
    for (int i = 0; i < MAX_SLABS; i++) in_use[i] = 1'b0;
    rst_n = 1'b0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_basic_ops();
    test_backpressure();
    test_exhaust_pool();
    test_random_mix(400);

    @(negedge clk);
    in_tvalid <= 1'b0;
    while (pending_grants.size() > 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0 && pending_grants.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
